### hdl/t88rg_pkg.sv
// Shared types and constants for the Taus88 random word generator.
package t88rg_pkg;

  typedef enum logic [1:0] {
    CMD_RESEED   = 2'd0,
    CMD_DRAW     = 2'd1,
    CMD_TRIANGLE = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_DRAW_MASK   = 2'd0,
    REG_DRAW_OFFSET = 2'd1,
    REG_SPARE_2     = 2'd2,
    REG_SPARE_3     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] one;
    logic [31:0] two;
    logic [31:0] three;
  } seeds_t;

  localparam logic [31:0] SEED_K1     = 32'h4a1fcf79;
  localparam logic [31:0] SEED_K2     = 32'hb86271cc;
  localparam logic [31:0] SEED_K3     = 32'h6c986d11;
  localparam logic [31:0] PEPPER_ZERO = 32'hfedcfedc;
  localparam logic [31:0] MASK_RESET  = 32'hffffffff;

endpackage

### hdl/t88rg_advance.sv
// One Taus88 recurrence step over the three seed components.
module t88rg_advance (
  input  t88rg_pkg::seeds_t seeds_in,
  output t88rg_pkg::seeds_t seeds_out,
  output logic [31:0]       word
);

  logic [31:0] b1, b2, b3;

  always_comb begin
    b1 = ((seeds_in.one << 13) ^ seeds_in.one) >> 19;
    seeds_out.one = ((seeds_in.one & 32'hfffffffe) << 12) ^ b1;
    b2 = ((seeds_in.two << 2) ^ seeds_in.two) >> 25;
    seeds_out.two = ((seeds_in.two & 32'hfffffff8) << 4) ^ b2;
    b3 = ((seeds_in.three << 3) ^ seeds_in.three) >> 11;
    seeds_out.three = ((seeds_in.three & 32'hfffffff0) << 17) ^ b3;
    word = seeds_out.one ^ seeds_out.two ^ seeds_out.three;
  end

endmodule

### hdl/taus88_random_generator_core.sv
// Top level: Taus88 generator with reseed, draw and triangle commands.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in_     | input     | in_tvalid/in_tready  | tuser: cmd; tdata: salt
//  out_    | output    | out_tvalid/out_tready| tdata: random_word, shaped_word, tri
//  cfg_    | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// A draw takes one recurrence step, then a load; a triangle takes two
// chained steps on the single step unit, then a load; a reseed takes two
// passes through the shared 16x16 pepper multiplier, each a multiply state
// and a mix state, then a load; an unused command goes straight to the load.
// Ready returns in the cycle after the load, so no new item is taken meanwhile.
// Reset (rst_n, synchronous) restores the seed constants, mask all ones, offset 0.
// A new item is taken while a finished result still waits in the output
// register; the sequencer holds in its load state while that register is full.
module taus88_random_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  input  logic [31:0] in_tdata,   // [31:0] salt
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [31:0] random_word, [63:32] shaped_word,
                                  // [86:64] triangle_sum, [87] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RMUL = 5'b00010,
    ST_RMIX = 5'b00100,
    ST_STEP = 5'b01000,
    ST_LOAD = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  t88rg_pkg::cmd_t     cmd_r, cmd_nxt;
  t88rg_pkg::seeds_t   seeds_r, seeds_nxt, step_seeds;
  logic [31:0]         work_r, work_nxt;      // salt being stirred
  logic [31:0]         prod_r, prod_nxt;      // pepper product
  logic                pass_r, pass_nxt;      // reseed pass / triangle step count
  logic [31:0]         word_r, word_nxt;
  logic [31:0]         first_r, first_nxt;
  logic [31:0]         mask_r, offset_r;
  logic                out_valid_r, out_valid_nxt;
  logic [87:0]         out_data_r, out_data_nxt;

  logic [31:0]         step_word;
  logic [31:0]         pepper, mixed, derived;
  logic [31:0]         res_word, res_shaped;
  logic [22:0]         res_tri;
  logic [22:0]         tri_full;

  t88rg_advance u_advance (
    .seeds_in  (seeds_r),
    .seeds_out (step_seeds),
    .word      (step_word)
  );

  // Pepper from the registered product, and the salt after mixing it in.
  always_comb begin
    pepper = (prod_r == 32'd0) ? t88rg_pkg::PEPPER_ZERO : prod_r;
    mixed  = work_r ^ pepper;
    if (pass_r == 1'b0) begin
      derived = t88rg_pkg::SEED_K2 ^ mixed ^ (mixed << 3);
      if (derived < 32'd8) derived = t88rg_pkg::SEED_K2;
    end else begin
      derived = t88rg_pkg::SEED_K3 ^ mixed ^ (mixed << 4);
      if (derived < 32'd16) derived = t88rg_pkg::SEED_K3;
    end
  end

  // Result fields; zero for reseed and the unused command.
  always_comb begin
    tri_full   = 23'((first_r >> 10) + (word_r >> 10));
    res_word   = 32'd0;
    res_shaped = 32'd0;
    res_tri    = 23'd0;
    case (cmd_r)
      t88rg_pkg::CMD_DRAW: begin
        res_word   = word_r;
        res_shaped = (word_r & mask_r) + offset_r;
      end
      t88rg_pkg::CMD_TRIANGLE: begin
        res_word   = word_r;
        res_shaped = (word_r & mask_r) + offset_r;
        res_tri    = tri_full;
      end
      default: begin
        res_word = 32'd0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    seeds_nxt     = seeds_r;
    work_nxt      = work_r;
    prod_nxt      = prod_r;
    pass_nxt      = pass_r;
    word_nxt      = word_r;
    first_nxt     = first_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt  = t88rg_pkg::cmd_t'(in_tuser);
          work_nxt = in_tdata;
          pass_nxt = 1'b0;
          case (t88rg_pkg::cmd_t'(in_tuser))
            t88rg_pkg::CMD_RESEED:   state_nxt = ST_RMUL;
            t88rg_pkg::CMD_DRAW:     state_nxt = ST_STEP;
            t88rg_pkg::CMD_TRIANGLE: state_nxt = ST_STEP;
            default:                 state_nxt = ST_LOAD;
          endcase
        end
      end
      ST_RMUL: begin
        // Multiply salt halves; on the first pass also set seed one.
        prod_nxt = {16'd0, work_r[31:16]} * {16'd0, work_r[15:0]};
        if (pass_r == 1'b0) begin
          seeds_nxt.one = t88rg_pkg::SEED_K1 ^ work_r ^ (work_r << 1);
          if (seeds_nxt.one < 32'd2) seeds_nxt.one = t88rg_pkg::SEED_K1;
        end
        state_nxt = ST_RMIX;
      end
      ST_RMIX: begin
        work_nxt = mixed;
        if (pass_r == 1'b0) begin
          seeds_nxt.two = derived;
          pass_nxt      = 1'b1;
          state_nxt     = ST_RMUL;
        end else begin
          seeds_nxt.three = derived;
          state_nxt       = ST_LOAD;
        end
      end
      ST_STEP: begin
        seeds_nxt = step_seeds;
        word_nxt  = step_word;
        first_nxt = word_r;
        if (cmd_r == t88rg_pkg::CMD_TRIANGLE && pass_r == 1'b0) begin
          pass_nxt = 1'b1;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {1'b0, res_tri, res_shaped, res_word};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      seeds_r.one   <= t88rg_pkg::SEED_K1;
      seeds_r.two   <= t88rg_pkg::SEED_K2;
      seeds_r.three <= t88rg_pkg::SEED_K3;
      mask_r        <= t88rg_pkg::MASK_RESET;
      offset_r      <= 32'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      seeds_r     <= seeds_nxt;
      if (cfg_we) begin
        case (t88rg_pkg::reg_idx_t'(cfg_index))
          t88rg_pkg::REG_DRAW_MASK:   mask_r   <= cfg_data;
          t88rg_pkg::REG_DRAW_OFFSET: offset_r <= cfg_data;
          default: begin
            // Drop writes to unused indexes.
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    work_r     <= work_nxt;
    prod_r     <= prod_nxt;
    pass_r     <= pass_nxt;
    word_r     <= word_nxt;
    first_r    <= first_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### tb/t88rg_checker.sv
// Checker for the Taus88 generator: predicts every result item and compares it.
`timescale 1ns / 1ps

module t88rg_checker
  import t88rg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  input  logic [31:0] in_tdata,   // [31:0] salt
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,  // [31:0] random_word, [63:32] shaped_word,
                                  // [86:64] triangle_sum, [87] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    logic [22:0] tri_sum;
    logic [31:0] shaped;
    logic [31:0] word;
  } draw_result_t;

  seeds_t       seeds;
  logic [31:0]  draw_mask;
  logic [31:0]  draw_offset;
  draw_result_t expected_draws[$];
  int           n_bad = 0;
  int           n_checked = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
  end

  // One step of the three-component recurrence.
  function automatic seeds_t taus_next(seeds_t s);
    seeds_t      n;
    logic [31:0] b;
    b       = ((s.one << 13) ^ s.one) >> 19;
    n.one   = ((s.one & 32'hfffffffe) << 12) ^ b;
    b       = ((s.two << 2) ^ s.two) >> 25;
    n.two   = ((s.two & 32'hfffffff8) << 4) ^ b;
    b       = ((s.three << 3) ^ s.three) >> 11;
    n.three = ((s.three & 32'hfffffff0) << 17) ^ b;
    return n;
  endfunction

  function automatic logic [31:0] word_of(seeds_t s);
    return s.one ^ s.two ^ s.three;
  endfunction

  function automatic logic [31:0] pepper_of(logic [31:0] v);
    logic [31:0] p;
    p = {16'h0, v[31:16]} * {16'h0, v[15:0]};
    return (p == 32'h0) ? PEPPER_ZERO : p;
  endfunction

  function automatic seeds_t seeds_from_salt(logic [31:0] salt);
    seeds_t      n;
    logic [31:0] v;
    logic [31:0] s;
    v       = salt;
    s       = SEED_K1 ^ v ^ (v << 1);
    n.one   = (s >= 32'd2) ? s : SEED_K1;
    v       = v ^ pepper_of(v);
    s       = SEED_K2 ^ v ^ (v << 3);
    n.two   = (s >= 32'd8) ? s : SEED_K2;
    v       = v ^ pepper_of(v);
    s       = SEED_K3 ^ v ^ (v << 4);
    n.three = (s >= 32'd16) ? s : SEED_K3;
    return n;
  endfunction

  always @(posedge clk) begin
    draw_result_t want;
    draw_result_t got;
    logic [31:0]  first;
    logic [31:0]  sum;
    if (!rst_n) begin
      seeds       = '{SEED_K1, SEED_K2, SEED_K3};
      draw_mask   = MASK_RESET;
      draw_offset = 32'h0;
      expected_draws.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_DRAW_MASK:   draw_mask = cfg_data;
          REG_DRAW_OFFSET: draw_offset = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want = '0;
        case (cmd_t'(in_tuser))
          CMD_RESEED: seeds = seeds_from_salt(in_tdata);
          CMD_DRAW: begin
            seeds       = taus_next(seeds);
            want.word   = word_of(seeds);
            want.shaped = (want.word & draw_mask) + draw_offset;
          end
          CMD_TRIANGLE: begin
            seeds        = taus_next(seeds);
            first        = word_of(seeds);
            seeds        = taus_next(seeds);
            want.word    = word_of(seeds);
            want.shaped  = (want.word & draw_mask) + draw_offset;
            sum          = (first >> 10) + (want.word >> 10);
            want.tri_sum = sum[22:0];
          end
          default: ;
        endcase
        expected_draws.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[86:0];
        if (expected_draws.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("checker: unexpected result item %h", out_tdata);
        end else begin
          want = expected_draws.pop_front();
          n_checked++;
          if (got != want || out_tdata[87]) begin
            n_bad++;
            if (n_bad <= 10)
              $display({"checker: item %0d word exp %h got %h, shaped exp %h got %h,",
                        " tri exp %h got %h, pad %b"},
                       n_checked, want.word, got.word, want.shaped, got.shaped,
                       want.tri_sum, got.tri_sum, out_tdata[87]);
          end
        end
      end
    end
    mismatches <= n_bad;
    pending    <= expected_draws.size();
    checked    <= n_checked;
  end

endmodule

### tb/tb.sv
// Testbench top for the Taus88 generator: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
  import t88rg_pkg::*;

  localparam int ITEMS_PER_PHASE = 230;
  localparam int PHASES          = 6;
  localparam int LONG_HOLD       = 80;    // receiver hold-off, in cycles
  localparam int IDLE_LIMIT      = 4000;  // cycles with no item moving on either side
  localparam int TAIL_CYCLES     = 20;    // run-out after the last result item, in cycles

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser   = CMD_NONE;     // [1:0] cmd
  logic [31:0] in_tdata   = 32'h0;        // [31:0] salt
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;                 // [31:0] random_word, [63:32] shaped_word,
                                          // [86:64] triangle_sum, [87] zero
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = REG_DRAW_MASK;
  logic [31:0] cfg_data   = 32'h0;

  int mismatches;
  int pending;
  int checked;

  int items_sent    = 0;
  int burst_left    = 0;
  int idle_cycles   = 0;
  int long_hold_req = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int ready_run     = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  taus88_random_generator_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  t88rg_checker i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  // Receiver: alternate ready and stalled runs of random length, with long
  // fully-ready stretches now and then. A hold-off request from the stimulus
  // side drops ready for a long hold-off so the block backs up into its input.
  always @(posedge clk) begin
    if (long_hold_req != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left    <= LONG_HOLD;
      out_tready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      ready_run  <= $urandom_range(0, 5);
    end else begin
      out_tready <= 1'b1;
      ready_run  <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 8);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: no item moved for %0d cycles, %0d still expected", idle_cycles, pending);
      $display("tb: done, errors");
      $finish;
    end
  end

  // Offer one item and hold it until it is taken. Sender works in bursts:
  // keep valid up within a burst, drop it for a random gap (or none) after.
  task automatic send_item(input cmd_t cmd, input logic [31:0] salt);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= salt;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      burst_left = $urandom_range(0, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Random item: mostly draws and triangles, some reseeds (a share of them
  // with a zero half so the pepper falls back), a few unused commands.
  task automatic send_random();
    int          pick;
    logic [31:0] salt;
    pick = $urandom_range(0, 99);
    salt = $urandom;
    if (pick < 9) begin
      case ($urandom_range(0, 5))
        0: salt[31:16] = 16'h0;
        1: salt[15:0]  = 16'h0;
        default: ;
      endcase
      send_item(CMD_RESEED, salt);
    end else if (pick < 12) begin
      send_item(CMD_NONE, salt);
    end else if (pick < 55) begin
      send_item(CMD_DRAW, salt);
    end else begin
      send_item(CMD_TRIANGLE, salt);
    end
  endtask

  // Drain: drop valid and wait until every expected result item is back.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] mask, input logic [31:0] offset,
                            input bit spare);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_DRAW_MASK;
    cfg_data  <= mask;
    @(posedge clk);
    cfg_index <= REG_DRAW_OFFSET;
    cfg_data  <= offset;
    @(posedge clk);
    if (spare) begin
      // unused indexes: must leave mask and offset alone
      cfg_index <= REG_SPARE_2;
      cfg_data  <= $urandom;
      @(posedge clk);
      cfg_index <= REG_SPARE_3;
      cfg_data  <= ~mask;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Undo x ^ (x << k): rebuild x from its low bits upward.
  function automatic logic [31:0] unshift_xor(logic [31:0] y, int k);
    logic [31:0] x;
    x = y;
    for (int i = 0; i < 32; i++) x = y ^ (x << k);
    return x;
  endfunction

  // Find a salt with salt ^ pepper(salt) == target, scanning even high halves
  // from h_from. For an even high half, bit i of the low half alone decides
  // bit i of the mixed low half, so the low half is solved bit by bit and
  // only the high half has to match.
  function automatic bit pepper_preimage(input logic [31:0] target, input int h_from,
                                         output logic [31:0] salt, output int h_hit);
    logic [31:0] l;
    logic [31:0] p;
    logic [15:0] hh;
    for (int h = h_from; h < 65536; h += 2) begin
      hh = h[15:0];
      l  = 32'h0;
      for (int i = 0; i < 16; i++) begin
        p = {16'h0, hh} * {16'h0, l[15:0]};
        if ((l[i] ^ p[i]) != target[i]) l[i] = 1'b1;
      end
      p = {16'h0, hh} * {16'h0, l[15:0]};
      if (l != 32'h0 && (hh ^ p[31:16]) == target[31:16]) begin
        salt  = {hh, l[15:0]};
        h_hit = h;
        return 1'b1;
      end
    end
    salt  = 32'h0;
    h_hit = 65536;
    return 1'b0;
  endfunction

  initial begin
    logic [31:0] small_one_salt;
    logic [31:0] small_two_salt;
    logic [31:0] small_three_salt;
    logic [31:0] mid;
    logic [31:0] mask;
    logic [31:0] offset;
    bit          have_two;
    bit          have_three;
    int          h_at;
    int          h_scan;
    int          unused_h;

    // Salts that drive each derived seed below its floor so it falls back
    // to its constant: the first directly, the second through one pepper
    // pass, the third through two.
    small_one_salt = unshift_xor(SEED_K1, 1);
    have_two       = 1'b0;
    for (int s = 0; s < 8 && !have_two; s++)
      have_two = pepper_preimage(unshift_xor(SEED_K2 ^ s, 3), 2, small_two_salt, h_at);
    have_three = 1'b0;
    for (int s = 0; s < 16 && !have_three; s++) begin
      h_scan = 2;
      while (!have_three &&
             pepper_preimage(unshift_xor(SEED_K3 ^ s, 4), h_scan, mid, h_at)) begin
        have_three = pepper_preimage(mid, 2, small_three_salt, unused_h);
        h_scan     = h_at + 2;
      end
    end

    // Hold reset at start, then release it once for the whole run.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, under the reset mask and offset.
    send_item(CMD_DRAW,     32'h0);
    send_item(CMD_TRIANGLE, 32'hffffffff);
    send_item(CMD_NONE,     32'hffffffff);
    send_item(CMD_RESEED,   32'h0);          // zero salt, zero product, pepper falls back
    send_item(CMD_DRAW,     32'h0);
    send_item(CMD_RESEED,   32'hffffffff);
    send_item(CMD_TRIANGLE, 32'h0);
    send_item(CMD_RESEED,   32'h0000abcd);   // high half zero
    send_item(CMD_DRAW,     32'h0);
    send_item(CMD_RESEED,   32'h5a5a0000);   // low half zero
    send_item(CMD_DRAW,     32'h0);
    send_item(CMD_RESEED,   small_one_salt);
    send_item(CMD_DRAW,     32'h0);
    if (have_two) begin
      send_item(CMD_RESEED, small_two_salt);
      send_item(CMD_DRAW,   32'h0);
    end
    if (have_three) begin
      send_item(CMD_RESEED,   small_three_salt);
      send_item(CMD_TRIANGLE, 32'h0);
    end
    send_item(CMD_NONE,     32'h0);
    send_item(CMD_DRAW,     32'h55555555);
    send_item(CMD_TRIANGLE, 32'haaaaaaaa);
    send_item(CMD_RESEED,   32'h80000001);
    send_item(CMD_TRIANGLE, 32'h0);
    send_item(CMD_DRAW,     32'h0);

    // Random part: one mask/offset setting per phase, extremes included.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin mask = 32'h00000000; offset = 32'h00000000; end
        1:       begin mask = 32'hffffffff; offset = 32'hffffffff; end
        2:       begin mask = 32'h0000ffff; offset = 32'h80000000; end
        3:       begin mask = 32'hffff0000; offset = 32'h00000001; end
        default: begin mask = $urandom;     offset = $urandom;     end
      endcase
      write_regs(mask, offset, ph == 0 || ph == 4);
      // stall the receiver for a long stretch while items keep coming
      if (ph == 2) long_hold_req <= long_hold_req + 1;
      repeat (ITEMS_PER_PHASE) send_random();
    end

    // Wait for the last result items, then let the pipeline run dry.
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d items sent, %0d result items checked, %0d mismatches", items_sent,
             checked, mismatches);
    $display("tb: covered reseed, draw, triangle and unused commands over %0d %s",
             PHASES + 1, "register settings");
    if (mismatches == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/t88rg_pkg.sv
hdl/t88rg_advance.sv
hdl/taus88_random_generator_core.sv
tb/t88rg_checker.sv
tb/tb.sv
